// File: hdl/fjsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fjsm_pkg;

    // Token classes produced by the front classifier
    typedef enum logic [3:0] {
        TOK_OTHER  = 4'd0,
        TOK_BLANK  = 4'd1,
        TOK_LBRACE = 4'd2,
        TOK_RBRACE = 4'd3,
        TOK_QUOTE  = 4'd4,
        TOK_BSLASH = 4'd5,
        TOK_COLON  = 4'd6,
        TOK_COMMA  = 4'd7,
        TOK_EOS    = 4'd8
    } tok_class_t;

    typedef struct packed {
        tok_class_t  cls;
        logic [7:0]  raw;
        logic [7:0]  unesc;
    } token_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] KIND_CHAR      = 3'd0;
    localparam logic [2:0] KIND_KEY_END   = 3'd1;
    localparam logic [2:0] KIND_VALUE_END = 3'd2;
    localparam logic [2:0] KIND_COMPLETE  = 3'd3;
    localparam logic [2:0] KIND_ERROR     = 3'd4;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_WANT_OPEN  = 3'd1;
    localparam logic [2:0] ERR_WANT_QUOTE = 3'd2;
    localparam logic [2:0] ERR_WANT_COLON = 3'd3;
    localparam logic [2:0] ERR_WANT_SEP   = 3'd4;
    localparam logic [2:0] ERR_BAD_ESCAPE = 3'd5;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;

    // Escape map: the named control escapes, everything else maps to itself
    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CH_LOW_B: r = CH_BS;
            CH_LOW_F: r = CH_FF;
            CH_LOW_N: r = CH_LF;
            CH_LOW_R: r = CH_CR;
            CH_LOW_T: r = CH_TAB;
            default:  r = c;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/fjsm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fjsm_front (
    input  wire logic           [7:0] data_byte,
    input  wire logic                 end_of_source,
    output fjsm_pkg::token_t          token
);

    fjsm_pkg::tok_class_t cls;

    // classify the byte into a token class; whitespace is space or 0x09..0x0D
    always_comb
    begin
        if (end_of_source)
        begin
            cls = fjsm_pkg::TOK_EOS;
        end
        else if (data_byte == fjsm_pkg::CH_SPACE ||
                 (data_byte >= fjsm_pkg::CH_TAB && data_byte <= fjsm_pkg::CH_CR))
        begin
            cls = fjsm_pkg::TOK_BLANK;
        end
        else
        begin
            case (data_byte)
                fjsm_pkg::CH_LBRACE: cls = fjsm_pkg::TOK_LBRACE;
                fjsm_pkg::CH_RBRACE: cls = fjsm_pkg::TOK_RBRACE;
                fjsm_pkg::CH_QUOTE:  cls = fjsm_pkg::TOK_QUOTE;
                fjsm_pkg::CH_BSLASH: cls = fjsm_pkg::TOK_BSLASH;
                fjsm_pkg::CH_COLON:  cls = fjsm_pkg::TOK_COLON;
                fjsm_pkg::CH_COMMA:  cls = fjsm_pkg::TOK_COMMA;
                default:             cls = fjsm_pkg::TOK_OTHER;
            endcase
        end
    end

    assign token.cls   = cls;
    assign token.raw   = data_byte;
    assign token.unesc = fjsm_pkg::unescape(data_byte);

endmodule

`default_nettype wire

// File: hdl/fjsm_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module fjsm_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire fjsm_pkg::token_t  push_data,
    output logic                   not_full,
    input  wire logic              pop,
    output logic                   not_empty,
    output fjsm_pkg::token_t       pop_data
);

    fjsm_pkg::token_t                  mem_reg [fjsm_pkg::QUEUE_DEPTH];
    logic [fjsm_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [fjsm_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [fjsm_pkg::QCNT_W-1:0]       count_reg,  count_next;

    localparam logic [fjsm_pkg::QPTR_W-1:0] LAST_PTR = fjsm_pkg::QPTR_W'(fjsm_pkg::QUEUE_DEPTH - 1);
    localparam logic [fjsm_pkg::QCNT_W-1:0] FULL_CNT = fjsm_pkg::QCNT_W'(fjsm_pkg::QUEUE_DEPTH);

    assign not_full  = (count_reg != FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/fjsm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fjsm_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              tok_valid,
    input  wire fjsm_pkg::token_t  tok,
    output logic                   tok_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic             [2:0] result_kind,
    output logic             [7:0] out_char,
    output logic             [2:0] error_code
);

    typedef enum logic [10:0] {
        PH_WAIT_OPEN    = 11'b000_0000_0001,
        PH_AFTER_OPEN   = 11'b000_0000_0010,
        PH_IN_KEY       = 11'b000_0000_0100,
        PH_KEY_ESC      = 11'b000_0000_1000,
        PH_AFTER_KEY    = 11'b000_0001_0000,
        PH_BEFORE_VALUE = 11'b000_0010_0000,
        PH_IN_VALUE     = 11'b000_0100_0000,
        PH_VALUE_ESC    = 11'b000_1000_0000,
        PH_AFTER_VALUE  = 11'b001_0000_0000,
        PH_BEFORE_KEY   = 11'b010_0000_0000,
        PH_FINISHED     = 11'b100_0000_0000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  kind_reg, kind_next;
    logic [7:0]  char_reg, char_next;
    logic [2:0]  err_reg,  err_next;
    logic        emit;
    logic        blank;

    // advance whenever the output slot is free or being drained
    assign tok_pop = tok_valid && (!out_valid_reg || out_ready);
    assign blank   = (tok.cls == fjsm_pkg::TOK_BLANK);

    always_comb
    begin
        phase_next = phase_reg;
        emit       = 1'b0;
        kind_next  = fjsm_pkg::KIND_CHAR;
        char_next  = 8'h00;
        err_next   = fjsm_pkg::ERR_NONE;

        if (tok.cls == fjsm_pkg::TOK_EOS)
        begin
            if (phase_reg != PH_FINISHED)
            begin
                emit       = 1'b1;
                kind_next  = fjsm_pkg::KIND_ERROR;
                phase_next = PH_FINISHED;
                case (phase_reg)
                    PH_WAIT_OPEN:   err_next = fjsm_pkg::ERR_WANT_OPEN;
                    PH_KEY_ESC,
                    PH_VALUE_ESC:   err_next = fjsm_pkg::ERR_BAD_ESCAPE;
                    PH_AFTER_KEY:   err_next = fjsm_pkg::ERR_WANT_COLON;
                    PH_AFTER_VALUE: err_next = fjsm_pkg::ERR_WANT_SEP;
                    default:        err_next = fjsm_pkg::ERR_WANT_QUOTE;
                endcase
            end
        end
        else
        begin
            case (phase_reg)
                PH_WAIT_OPEN:
                begin
                    if (tok.cls == fjsm_pkg::TOK_LBRACE)
                    begin
                        phase_next = PH_AFTER_OPEN;
                    end
                    else if (!blank)
                    begin
                        emit       = 1'b1;
                        kind_next  = fjsm_pkg::KIND_ERROR;
                        err_next   = fjsm_pkg::ERR_WANT_OPEN;
                        phase_next = PH_FINISHED;
                    end
                end
                PH_AFTER_OPEN:
                begin
                    if (tok.cls == fjsm_pkg::TOK_RBRACE)
                    begin
                        emit       = 1'b1;
                        kind_next  = fjsm_pkg::KIND_COMPLETE;
                        phase_next = PH_FINISHED;
                    end
                    else if (tok.cls == fjsm_pkg::TOK_QUOTE)
                    begin
                        phase_next = PH_IN_KEY;
                    end
                    else if (!blank)
                    begin
                        emit       = 1'b1;
                        kind_next  = fjsm_pkg::KIND_ERROR;
                        err_next   = fjsm_pkg::ERR_WANT_QUOTE;
                        phase_next = PH_FINISHED;
                    end
                end
                PH_IN_KEY, PH_IN_VALUE:
                begin
                    emit = 1'b1;
                    if (tok.cls == fjsm_pkg::TOK_QUOTE)
                    begin
                        if (phase_reg == PH_IN_KEY)
                        begin
                            kind_next  = fjsm_pkg::KIND_KEY_END;
                            phase_next = PH_AFTER_KEY;
                        end
                        else
                        begin
                            kind_next  = fjsm_pkg::KIND_VALUE_END;
                            phase_next = PH_AFTER_VALUE;
                        end
                    end
                    else if (tok.cls == fjsm_pkg::TOK_BSLASH)
                    begin
                        emit       = 1'b0;
                        phase_next = (phase_reg == PH_IN_KEY) ? PH_KEY_ESC : PH_VALUE_ESC;
                    end
                    else
                    begin
                        char_next = tok.raw;
                    end
                end
                PH_KEY_ESC, PH_VALUE_ESC:
                begin
                    emit       = 1'b1;
                    char_next  = tok.unesc;
                    phase_next = (phase_reg == PH_KEY_ESC) ? PH_IN_KEY : PH_IN_VALUE;
                end
                PH_AFTER_KEY:
                begin
                    if (tok.cls == fjsm_pkg::TOK_COLON)
                    begin
                        phase_next = PH_BEFORE_VALUE;
                    end
                    else if (!blank)
                    begin
                        emit       = 1'b1;
                        kind_next  = fjsm_pkg::KIND_ERROR;
                        err_next   = fjsm_pkg::ERR_WANT_COLON;
                        phase_next = PH_FINISHED;
                    end
                end
                PH_BEFORE_VALUE, PH_BEFORE_KEY:
                begin
                    if (tok.cls == fjsm_pkg::TOK_QUOTE)
                    begin
                        phase_next = (phase_reg == PH_BEFORE_KEY) ? PH_IN_KEY : PH_IN_VALUE;
                    end
                    else if (!blank)
                    begin
                        emit       = 1'b1;
                        kind_next  = fjsm_pkg::KIND_ERROR;
                        err_next   = fjsm_pkg::ERR_WANT_QUOTE;
                        phase_next = PH_FINISHED;
                    end
                end
                PH_AFTER_VALUE:
                begin
                    if (tok.cls == fjsm_pkg::TOK_RBRACE)
                    begin
                        emit       = 1'b1;
                        kind_next  = fjsm_pkg::KIND_COMPLETE;
                        phase_next = PH_FINISHED;
                    end
                    else if (tok.cls == fjsm_pkg::TOK_COMMA)
                    begin
                        phase_next = PH_BEFORE_KEY;
                    end
                    else if (!blank)
                    begin
                        emit       = 1'b1;
                        kind_next  = fjsm_pkg::KIND_ERROR;
                        err_next   = fjsm_pkg::ERR_WANT_SEP;
                        phase_next = PH_FINISHED;
                    end
                end
                default:
                begin
                    // finished or an illegal code: drop the item
                    phase_next = PH_FINISHED;
                end
            endcase
        end

        if (tok_pop && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_pop && emit)
        begin
            kind_reg <= kind_next;
            char_reg <= char_next;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT_OPEN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tok_pop)
            begin
                phase_reg <= phase_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign out_char    = char_reg;
    assign error_code  = err_reg;

endmodule

`default_nettype wire

// File: hdl/flat_json_string_map_tokenizer_top.sv
// A byte's token passes the token queue before its result is registered for out_valid.
// Throughput: one byte per cycle sustained while out_ready is held high; the parser state
// machine in the back end takes one queued token each cycle its output register is free or being drained.
// Reset (rst_n, asynchronous, active low): token queue empty, no result pending,
// parser waits for the opening brace.
`timescale 1ns / 1ps
`default_nettype none

module flat_json_string_map_tokenizer_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input request: one source byte or the end-of-source mark
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_source,
    // output request: one result
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [2:0] result_kind,
    output logic      [7:0] out_char,
    output logic      [2:0] error_code
);

    fjsm_pkg::token_t front_tok;
    fjsm_pkg::token_t queue_tok;
    logic             q_not_full;
    logic             q_not_empty;
    logic             q_pop;

    // Front end: classify the byte (whitespace, structural character, quote,
    // backslash, end mark) and precompute its escape translation.
    fjsm_front u_front (
        .data_byte     (data_byte),
        .end_of_source (end_of_source),
        .token         (front_tok)
    );

    // Accept whenever the queue has room; this does not depend on the back end
    // draining in the same cycle, so the input side never waits on out_ready
    // combinationally.
    assign in_ready = q_not_full;

    // Short token queue decoupling the classifier from the parser.
    fjsm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && q_not_full),
        .push_data (front_tok),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (queue_tok)
    );

    // Back end: the parse phase machine. Each token silently changes or keeps the
    // phase, or loads one result into the output register. After completion or an
    // error the machine sits in its terminal phase and drops every further token.
    fjsm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .tok_valid   (q_not_empty),
        .tok         (queue_tok),
        .tok_pop     (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .out_char    (out_char),
        .error_code  (error_code)
    );

endmodule

`default_nettype wire
